// ----- rtl/hqlu_pkg.sv -----
// shared widths, register codes, sequencer states and saturation for the q-learning update unit
`default_nettype none

package hqlu_pkg;

  // default table geometry
  localparam int NUM_STATES_DEF  = 256;
  localparam int NUM_ACTIONS_DEF = 16;

  // fixed field widths
  localparam int STATE_IN_W  = 8;
  localparam int ACTION_IN_W = 4;
  localparam int VALUE_W     = 32;
  localparam int RATE_W      = 17;
  localparam int CFG_IDX_W   = 2;

  // internal arithmetic widths
  localparam int DELTA_W = 36;
  localparam int PROD_W  = RATE_W + 1 + DELTA_W;
  localparam int FRAC_W  = 16;
  localparam int SCALE_W = PROD_W - FRAC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL     = 2'd2;

  // register reset values
  localparam logic [RATE_W-1:0] DISCOUNT_RST = 17'd58982;
  localparam logic [RATE_W-1:0] RISE_RST     = 17'd6554;
  localparam logic [RATE_W-1:0] FALL_RST     = 17'd655;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_LAST  = 8'b0000_1000,
    ST_MULD  = 8'b0001_0000,
    ST_DELTA = 8'b0010_0000,
    ST_MULR  = 8'b0100_0000,
    ST_UPD   = 8'b1000_0000
  } state_e;

  // clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [SCALE_W-1:0] x);
    logic hi_zero;
    logic hi_ones;
    hi_zero = ~|x[SCALE_W-2:VALUE_W-1];
    hi_ones = &x[SCALE_W-2:VALUE_W-1];
    if (!x[SCALE_W-1] && !hi_zero) begin
      sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (x[SCALE_W-1] && !hi_ones) begin
      sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_value = x[VALUE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hqlu_ram.sv -----
// single-port-write, single-port-read value table with registered read data
`default_nettype none

module hqlu_ram #(
  parameter int DEPTH  = hqlu_pkg::NUM_STATES_DEF * hqlu_pkg::NUM_ACTIONS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [ADDR_W-1:0]                  waddr_i,
  input  wire logic [hqlu_pkg::VALUE_W-1:0]       wdata_i,
  input  wire logic [ADDR_W-1:0]                  raddr_i,
  output logic      [hqlu_pkg::VALUE_W-1:0]       rdata_o
);

  logic [hqlu_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [hqlu_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/hqlu_mul.sv -----
// shared rate multiplier with registered product and floor scaling by 2^-16
`default_nettype none

module hqlu_mul (
  input  wire logic                                       clk_i,
  input  wire logic        [hqlu_pkg::RATE_W-1:0]         rate_i,
  input  wire logic signed [hqlu_pkg::DELTA_W-1:0]        val_i,
  output logic signed      [hqlu_pkg::SCALE_W-1:0]        scaled_o
);

  logic signed [hqlu_pkg::PROD_W-1:0] prod_d;
  logic signed [hqlu_pkg::PROD_W-1:0] prod_q;

  // unsigned rate times signed value, exact
  assign prod_d = $signed({1'b0, rate_i}) * val_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // dropping the fraction bits of a two's complement word is a floor
  assign scaled_o = prod_q[hqlu_pkg::PROD_W-1:hqlu_pkg::FRAC_W];

endmodule

`default_nettype wire

// ----- rtl/hysteretic_q_learning_update_unit.sv -----
// top level: hysteretic q-learning update sequencer around a value table and a shared multiplier
`default_nettype none

// channel | direction | handshake                 | word
// --------+-----------+---------------------------+-----------------------------------------
// in      | sink      | in_valid_i / in_stall_o   | cur_state, action_taken, next_state, reward
// out     | source    | out_valid_o / out_stall_i | new_value, next_row_max, was_rise
// cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index, cfg_data
//
// a word runs through these steps before the next is accepted, in_stall_o high meanwhile:
// the row walk (old entry, then the next row, read data trailing the address), the discount
// multiply, the delta add, the rate multiply, the write-back, then idle for the next word
// after reset the whole table is swept to zero, in_stall_o high meanwhile
// a finished word waits in the output register while the next is taken; a second finished
// word holds the write-back for as long as out_stall_i holds the first; cfg writes act at once

module hysteretic_q_learning_update_unit #(
  parameter int NUM_STATES  = hqlu_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = hqlu_pkg::NUM_ACTIONS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // input words
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic        [hqlu_pkg::STATE_IN_W-1:0]  cur_state_i,
  input  wire logic        [hqlu_pkg::ACTION_IN_W-1:0] action_taken_i,
  input  wire logic        [hqlu_pkg::STATE_IN_W-1:0]  next_state_i,
  input  wire logic signed [hqlu_pkg::VALUE_W-1:0]     reward_i,
  // result words
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed      [hqlu_pkg::VALUE_W-1:0]     new_value_o,
  output logic signed      [hqlu_pkg::VALUE_W-1:0]     next_row_max_o,
  output logic                                         was_rise_o,
  // configuration writes
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic        [hqlu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic        [hqlu_pkg::RATE_W-1:0]      cfg_data_i
);

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KW     = $clog2(NUM_ACTIONS + 1);
  localparam int VW     = hqlu_pkg::VALUE_W;
  localparam int DW     = hqlu_pkg::DELTA_W;
  localparam int SW     = hqlu_pkg::SCALE_W;
  localparam int S_IN   = 2 ** hqlu_pkg::STATE_IN_W;
  localparam int A_IN   = 2 ** hqlu_pkg::ACTION_IN_W;

  localparam logic [ADDR_W-1:0] ROW_LEN  = ADDR_W'(NUM_ACTIONS);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);
  localparam logic [KW-1:0]     LAST_K   = KW'(NUM_ACTIONS - 1);
  localparam logic [KW-1:0]     K_LIMIT  = KW'(NUM_ACTIONS);

  // ---------------------------------------------------------------------------
  // index wrap tables, built at elaboration
  // ---------------------------------------------------------------------------
  logic [hqlu_pkg::STATE_IN_W-1:0]  state_wrap  [S_IN];
  logic [hqlu_pkg::ACTION_IN_W-1:0] action_wrap [A_IN];

  for (genvar gi = 0; gi < S_IN; gi++) begin : g_state_wrap
    assign state_wrap[gi] = hqlu_pkg::STATE_IN_W'(gi % NUM_STATES);
  end

  for (genvar gj = 0; gj < A_IN; gj++) begin : g_action_wrap
    assign action_wrap[gj] = hqlu_pkg::ACTION_IN_W'(gj % NUM_ACTIONS);
  end

  logic [ADDR_W-1:0] idx_in;
  logic [ADDR_W-1:0] base_in;

  // row base is state times row length, entry adds the action
  assign idx_in  = ADDR_W'(ADDR_W'(state_wrap[cur_state_i]) * ROW_LEN)
                 + ADDR_W'(action_wrap[action_taken_i]);
  assign base_in = ADDR_W'(ADDR_W'(state_wrap[next_state_i]) * ROW_LEN);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [hqlu_pkg::RATE_W-1:0] discount_q;
  logic [hqlu_pkg::RATE_W-1:0] rise_rate_q;
  logic [hqlu_pkg::RATE_W-1:0] fall_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q  <= hqlu_pkg::DISCOUNT_RST;
      rise_rate_q <= hqlu_pkg::RISE_RST;
      fall_rate_q <= hqlu_pkg::FALL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hqlu_pkg::CFG_DISCOUNT: discount_q  <= cfg_data_i;
        hqlu_pkg::CFG_RISE:     rise_rate_q <= cfg_data_i;
        hqlu_pkg::CFG_FALL:     fall_rate_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer state and working registers
  // ---------------------------------------------------------------------------
  hqlu_pkg::state_e state_q, state_d;

  logic [ADDR_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [KW-1:0]           k_q, k_d;
  logic [ADDR_W-1:0]       idx_q, idx_d;
  logic [ADDR_W-1:0]       base_q, base_d;
  logic signed [VW-1:0]    rew_q, rew_d;
  logic signed [VW-1:0]    q_q, q_d;          // old Q(state, action)
  logic signed [VW-1:0]    mx_q, mx_d;        // running row maximum
  logic signed [DW-1:0]    delta_q, delta_d;
  logic                    rise_q, rise_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [VW-1:0]    new_value_q, new_value_d;
  logic signed [VW-1:0]    row_max_q, row_max_d;
  logic                    was_rise_q, was_rise_d;

  // table port
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [VW-1:0]           mem_wdata;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [VW-1:0]           mem_rdata;
  logic signed [VW-1:0]    rd_val;

  // shared multiplier port
  logic [hqlu_pkg::RATE_W-1:0] mul_rate;
  logic signed [DW-1:0]        mul_val;
  logic signed [SW-1:0]        scaled;

  logic                    in_accept;
  logic                    out_free;
  logic signed [SW-1:0]    delta_wide;
  logic signed [SW-1:0]    sum_wide;
  logic signed [VW-1:0]    new_value;

  assign rd_val    = $signed(mem_rdata);
  assign in_stall_o = (state_q != hqlu_pkg::ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  // output register can take a word this cycle
  assign out_free  = !out_valid_q || !out_stall_i;

  // delta = reward + floor(discount * max) - old value, kept wide, never clamped
  assign delta_wide = $signed({{(SW-VW){rew_q[VW-1]}}, rew_q}) + scaled
                    - $signed({{(SW-VW){q_q[VW-1]}}, q_q});
  // updated value before saturation
  assign sum_wide   = $signed({{(SW-VW){q_q[VW-1]}}, q_q}) + scaled;
  assign new_value  = hqlu_pkg::sat_value(sum_wide);

  // multiplier inputs: discount times max first, then the chosen rate times delta;
  // held through the write-back state so a stalled output keeps its product
  always_comb begin
    if (state_q == hqlu_pkg::ST_MULR || state_q == hqlu_pkg::ST_UPD) begin
      mul_rate = rise_q ? rise_rate_q : fall_rate_q;
      mul_val  = delta_q;
    end else begin
      mul_rate = discount_q;
      mul_val  = $signed({{(DW-VW){mx_q[VW-1]}}, mx_q});
    end
  end

  // read address: old entry at accept, then the next row one entry a cycle
  always_comb begin
    case (state_q)
      hqlu_pkg::ST_IDLE: mem_raddr = idx_in;
      hqlu_pkg::ST_SCAN: mem_raddr = base_q + ADDR_W'(k_q);
      default:           mem_raddr = idx_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    k_d         = k_q;
    idx_d       = idx_q;
    base_d      = base_q;
    rew_d       = rew_q;
    q_d         = q_q;
    mx_d        = mx_q;
    delta_d     = delta_q;
    rise_d      = rise_q;
    out_valid_d = out_valid_q;
    new_value_d = new_value_q;
    row_max_d   = row_max_q;
    was_rise_d  = was_rise_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = new_value;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      hqlu_pkg::ST_CLEAR: begin
        // zero sweep over the whole table after reset
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_ADR) begin
          state_d = hqlu_pkg::ST_IDLE;
        end
      end
      hqlu_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_d   = idx_in;
          base_d  = base_in;
          rew_d   = reward_i;
          k_d     = '0;
          state_d = hqlu_pkg::ST_SCAN;
        end
      end
      hqlu_pkg::ST_SCAN: begin
        // read data comes the cycle after its address
        if (k_q == '0) begin
          q_d = rd_val;
        end else if (k_q == KW'(1)) begin
          mx_d = rd_val;
        end else if (rd_val > mx_q) begin
          mx_d = rd_val;
        end
        k_d = k_q + 1'b1;
        if (k_q == LAST_K) begin
          state_d = hqlu_pkg::ST_LAST;
        end
      end
      hqlu_pkg::ST_LAST: begin
        // last entry of the row
        if (rd_val > mx_q) begin
          mx_d = rd_val;
        end
        state_d = hqlu_pkg::ST_MULD;
      end
      hqlu_pkg::ST_MULD: begin
        state_d = hqlu_pkg::ST_DELTA;
      end
      hqlu_pkg::ST_DELTA: begin
        delta_d = delta_wide[DW-1:0];
        rise_d  = !delta_wide[SW-1];
        state_d = hqlu_pkg::ST_MULR;
      end
      hqlu_pkg::ST_MULR: begin
        state_d = hqlu_pkg::ST_UPD;
      end
      hqlu_pkg::ST_UPD: begin
        if (out_free) begin
          mem_we      = 1'b1;
          mem_waddr   = idx_q;
          mem_wdata   = new_value;
          out_valid_d = 1'b1;
          new_value_d = new_value;
          row_max_d   = mx_q;
          was_rise_d  = rise_q;
          state_d     = hqlu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hqlu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hqlu_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    base_q      <= base_d;
    rew_q       <= rew_d;
    q_q         <= q_d;
    mx_q        <= mx_d;
    delta_q     <= delta_d;
    rise_q      <= rise_d;
    new_value_q <= new_value_d;
    row_max_q   <= row_max_d;
    was_rise_q  <= was_rise_d;
  end

  assign out_valid_o    = out_valid_q;
  assign new_value_o    = new_value_q;
  assign next_row_max_o = row_max_q;
  assign was_rise_o     = was_rise_q;

  // ---------------------------------------------------------------------------
  // value table and shared multiplier
  // ---------------------------------------------------------------------------
  hqlu_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hqlu_mul u_mul (
    .clk_i    (clk_i),
    .rate_i   (mul_rate),
    .val_i    (mul_val),
    .scaled_o (scaled)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == hqlu_pkg::ST_SCAN && k_q == '0))
    else $error("accepted word did not start the row walk");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hqlu_pkg::ST_CLEAR) |-> in_stall_o)
    else $error("input taken during table clear");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hqlu_pkg::ST_UPD && mem_we))
    else $error("result raised without a table write-back");

  a_scan_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hqlu_pkg::ST_SCAN) |-> (k_q < K_LIMIT))
    else $error("row walk ran past the row");

  a_write_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != hqlu_pkg::ST_CLEAR) |-> (mem_waddr == idx_q && out_free))
    else $error("write-back at wrong entry or into a full output register");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the hysteretic q-learning update unit
`timescale 1ns / 1ps

module testbench;

  localparam int ROW_LEN     = hqlu_pkg::NUM_ACTIONS_DEF;
  localparam int TABLE_DEPTH = hqlu_pkg::NUM_STATES_DEF * hqlu_pkg::NUM_ACTIONS_DEF;
  localparam int WORD_CYCLES = ROW_LEN + 6;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_WORDS = 305;

  // index past the last register, writes there must be dropped
  localparam logic [hqlu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  typedef struct {
    logic [hqlu_pkg::STATE_IN_W-1:0]      origin;
    logic [hqlu_pkg::ACTION_IN_W-1:0]     action;
    logic [hqlu_pkg::STATE_IN_W-1:0]      target;
    logic signed [hqlu_pkg::VALUE_W-1:0]  reward;
  } transition_t;

  typedef struct packed {
    logic signed [hqlu_pkg::VALUE_W-1:0] new_value;
    logic signed [hqlu_pkg::VALUE_W-1:0] row_max;
    logic                                was_rise;
  } q_update_t;

  // dut ports
  logic                                 clk_i          = 1'b0;
  logic                                 rst_ni         = 1'b0;
  logic                                 in_valid_i     = 1'b0;
  logic                                 in_stall_o;
  logic [hqlu_pkg::STATE_IN_W-1:0]      cur_state_i    = '0;
  logic [hqlu_pkg::ACTION_IN_W-1:0]     action_taken_i = '0;
  logic [hqlu_pkg::STATE_IN_W-1:0]      next_state_i   = '0;
  logic signed [hqlu_pkg::VALUE_W-1:0]  reward_i       = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i    = 1'b0;
  logic signed [hqlu_pkg::VALUE_W-1:0]  new_value_o;
  logic signed [hqlu_pkg::VALUE_W-1:0]  next_row_max_o;
  logic                                 was_rise_o;
  logic                                 cfg_valid_i    = 1'b0;
  logic                                 cfg_ready_o;
  logic [hqlu_pkg::CFG_IDX_W-1:0]       cfg_index_i    = '0;
  logic [hqlu_pkg::RATE_W-1:0]          cfg_data_i     = '0;

  // shadow of the q table and the rate registers
  logic signed [hqlu_pkg::VALUE_W-1:0] q_shadow [TABLE_DEPTH];
  logic [hqlu_pkg::RATE_W-1:0]         discount_q = hqlu_pkg::DISCOUNT_RST;
  logic [hqlu_pkg::RATE_W-1:0]         rise_q     = hqlu_pkg::RISE_RST;
  logic [hqlu_pkg::RATE_W-1:0]         fall_q     = hqlu_pkg::FALL_RST;

  transition_t pending_words [$];
  q_update_t   expected_updates [$];

  int  words_queued    = 0;
  int  words_taken     = 0;
  int  words_checked   = 0;
  int  mismatch_count  = 0;
  int  fall_updates    = 0;
  int  clamped_updates = 0;
  int  settings_used   = 1;
  int  cycle_count     = 0;
  int  send_gap        = 0;
  int  stall_left      = 0;
  int  backpressure_left = 0;
  int  hold_at         = 400;
  logic steady         = 1'b0;

  hysteretic_q_learning_update_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cur_state_i    (cur_state_i),
    .action_taken_i (action_taken_i),
    .next_state_i   (next_state_i),
    .reward_i       (reward_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_value_o    (new_value_o),
    .next_row_max_o (next_row_max_o),
    .was_rise_o     (was_rise_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) q_shadow[i] = '0;
  end

  // one q update: row max of the target, delta, rise or fall step, clamp
  function automatic q_update_t apply_transition(transition_t w);
    q_update_t                           res;
    logic signed [hqlu_pkg::VALUE_W-1:0] best;
    logic signed [hqlu_pkg::VALUE_W-1:0] old_q;
    logic [hqlu_pkg::RATE_W-1:0]         gain;
    longint                              delta;
    longint                              sum;
    best = q_shadow[{w.target, 4'd0}];
    for (int k = 1; k < ROW_LEN; k++) begin
      if (q_shadow[{w.target, k[3:0]}] > best) best = q_shadow[{w.target, k[3:0]}];
    end
    old_q = q_shadow[{w.origin, w.action}];
    // >>> on a signed longint floors, as the hardware truncates
    delta = longint'(w.reward) + ((longint'(discount_q) * longint'(best)) >>> 16)
            - longint'(old_q);
    res.was_rise = (delta >= 0);
    gain = res.was_rise ? rise_q : fall_q;
    sum = longint'(old_q) + ((longint'(gain) * delta) >>> 16);
    if (sum > VALUE_MAX) begin
      res.new_value = VALUE_MAX[hqlu_pkg::VALUE_W-1:0];
      clamped_updates++;
    end else if (sum < VALUE_MIN) begin
      res.new_value = VALUE_MIN[hqlu_pkg::VALUE_W-1:0];
      clamped_updates++;
    end else begin
      res.new_value = sum[hqlu_pkg::VALUE_W-1:0];
    end
    if (!res.was_rise) fall_updates++;
    res.row_max = best;
    q_shadow[{w.origin, w.action}] = res.new_value;
    return res;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 60) return 0;
    if (sel < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(15, 60));
  endfunction

  function automatic logic [hqlu_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'd1;
      2:       return 17'd65536;
      3:       return '1;
      default: return hqlu_pkg::RATE_W'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic signed [hqlu_pkg::VALUE_W-1:0] pick_reward();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
    if (sel < 9) return int'($urandom_range(0, 32'h400_0000)) - 32'sh200_0000;
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic add_word(input logic [hqlu_pkg::STATE_IN_W-1:0] s,
                          input logic [hqlu_pkg::ACTION_IN_W-1:0] a,
                          input logic [hqlu_pkg::STATE_IN_W-1:0] ns,
                          input logic signed [hqlu_pkg::VALUE_W-1:0] r);
    transition_t w;
    w.origin = s;
    w.action = a;
    w.target = ns;
    w.reward = r;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // valid stays up across back-to-back writes, last drops it
  task automatic write_reg(input logic [hqlu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hqlu_pkg::RATE_W-1:0] val,
                           input logic last);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hqlu_pkg::CFG_DISCOUNT: discount_q = val;
      hqlu_pkg::CFG_RISE:     rise_q     = val;
      hqlu_pkg::CFG_FALL:     fall_q     = val;
      default:      ;
    endcase
    if (last) begin
      cfg_valid_i <= 1'b0;
      settings_used++;
    end
  endtask

  task automatic wait_drained();
    while (words_checked != words_queued) @(posedge clk_i);
  endtask

  // input driver, fed from pending_words
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    transition_t w;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      cur_state_i    <= '0;
      action_taken_i <= '0;
      next_state_i   <= '0;
      reward_i       <= '0;
      send_gap       = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        w.origin = cur_state_i;
        w.action = action_taken_i;
        w.target = next_state_i;
        w.reward = reward_i;
        expected_updates.push_back(apply_transition(w));
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          cur_state_i    <= w.origin;
          action_taken_i <= w.action;
          next_state_i   <= w.target;
          reward_i       <= w.reward;
          in_valid_i     <= 1'b1;
          send_gap       = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result stall: random bursts, plus long holds that back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (words_taken >= hold_at) begin
        backpressure_left = HOLD_CYCLES;
        hold_at += 700;
      end
      if (backpressure_left != 0) begin
        backpressure_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  = pick_gap();
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_results
    q_update_t exp_upd;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (expected_updates.size() == 0) begin
        $error("result word with no transition pending");
        mismatch_count++;
      end else begin
        exp_upd = expected_updates.pop_front();
        if (new_value_o !== exp_upd.new_value) begin
          $error("new_value: expected %0d, got %0d", exp_upd.new_value, new_value_o);
          mismatch_count++;
        end
        if (next_row_max_o !== exp_upd.row_max) begin
          $error("next_row_max: expected %0d, got %0d", exp_upd.row_max, next_row_max_o);
          mismatch_count++;
        end
        if (was_rise_o !== exp_upd.was_rise) begin
          $error("was_rise: expected %0d, got %0d", exp_upd.was_rise, was_rise_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [hqlu_pkg::STATE_IN_W-1:0] hot_states [6];
    logic [hqlu_pkg::STATE_IN_W-1:0] s;
    logic [hqlu_pkg::STATE_IN_W-1:0] ns;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset rates: zero table, extremes of every field, self loops, floor on tiny negatives
    add_word(8'd0, 4'd0, 8'd0, '0);
    add_word(8'd255, 4'd15, 8'd255, 32'sh7fff_ffff);
    add_word(8'd255, 4'd15, 8'd255, 32'sh7fff_ffff);
    add_word(8'd0, 4'd15, 8'd255, 32'sh8000_0000);
    add_word(8'd255, 4'd0, 8'd0, 32'sh8000_0000);
    add_word(8'd1, 4'd1, 8'd255, -32'sd1);
    add_word(8'd1, 4'd2, 8'd1, 32'sd1);
    add_word(8'd128, 4'd8, 8'd255, 32'sh0001_0000);
    add_word(8'd127, 4'd7, 8'd128, -32'sh0001_0000);
    wait_drained();

    // every register at its top code, unknown index must be ignored
    write_reg(CFG_UNUSED, '1, 1'b0);
    write_reg(hqlu_pkg::CFG_DISCOUNT, '1, 1'b0);
    write_reg(hqlu_pkg::CFG_RISE, '1, 1'b0);
    write_reg(hqlu_pkg::CFG_FALL, '1, 1'b1);
    repeat (3) add_word(8'd7, 4'd3, 8'd7, 32'sh7fff_ffff);
    repeat (3) add_word(8'd8, 4'd4, 8'd8, 32'sh8000_0000);
    add_word(8'd7, 4'd3, 8'd8, 32'sh8000_0000);
    add_word(8'd8, 4'd4, 8'd7, 32'sh7fff_ffff);
    add_word(8'd255, 4'd15, 8'd7, '0);
    wait_drained();

    // zero rates: table must hold still
    write_reg(hqlu_pkg::CFG_DISCOUNT, '0, 1'b0);
    write_reg(hqlu_pkg::CFG_RISE, '0, 1'b0);
    write_reg(hqlu_pkg::CFG_FALL, '0, 1'b1);
    add_word(8'd7, 4'd3, 8'd7, 32'sh7fff_ffff);
    add_word(8'd8, 4'd4, 8'd8, 32'sh8000_0000);
    add_word(8'd0, 4'd0, 8'd255, -32'sd1);
    wait_drained();

    write_reg(hqlu_pkg::CFG_DISCOUNT, 17'd65536, 1'b0);
    write_reg(hqlu_pkg::CFG_RISE, 17'd1, 1'b0);
    write_reg(hqlu_pkg::CFG_FALL, 17'd65536, 1'b1);
    add_word(8'd8, 4'd4, 8'd7, 32'sh8000_0000);
    add_word(8'd7, 4'd3, 8'd255, 32'sh7fff_ffff);
    wait_drained();

    // random phases: most traffic on a few hot states so rows build up values
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      steady = (phase == 3);
      write_reg(CFG_UNUSED, hqlu_pkg::RATE_W'($urandom), 1'b0);
      write_reg(hqlu_pkg::CFG_DISCOUNT, pick_rate(), 1'b0);
      write_reg(hqlu_pkg::CFG_RISE, pick_rate(), 1'b0);
      write_reg(hqlu_pkg::CFG_FALL, pick_rate(), 1'b1);
      foreach (hot_states[i]) hot_states[i] = 8'($urandom_range(0, 255));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        s  = ($urandom_range(0, 9) < 8) ? hot_states[$urandom_range(0, 5)]
                                        : 8'($urandom_range(0, 255));
        ns = ($urandom_range(0, 9) < 8) ? hot_states[$urandom_range(0, 5)]
                                        : 8'($urandom_range(0, 255));
        add_word(s, 4'($urandom_range(0, 15)), ns, pick_reward());
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (2 * WORD_CYCLES) @(posedge clk_i);
    if (expected_updates.size() != 0) begin
      $error("%0d expected results never arrived", expected_updates.size());
      mismatch_count++;
    end
    $display("checked %0d q updates over %0d rate settings", words_checked, settings_used);
    $display("%0d used the fall rate, %0d hit the saturation clamp",
             fall_updates, clamped_updates);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
